### hdl/aging_dedup_table_defines.svh
// Assertion macros used by the aging dedup table RTL.
`ifndef AGING_DEDUP_TABLE_DEFINES_SVH
`define AGING_DEDUP_TABLE_DEFINES_SVH

// Checked on every clock edge, reset excluded.
`define ADT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ADT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/adt_pkg.sv
package adt_pkg;

  localparam int unsigned Slots = 32;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [31:0] LifetimeReset = 32'd5000;

  typedef enum logic {
    OpAge    = 1'b0,
    OpNotify = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StSwept    = 3'd0,
    StHit      = 3'd1,
    StInserted = 3'd2,
    StNotQual  = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_idx;
    logic             free_found;
    logic [SlotW-1:0] free_idx;
  } lookup_t;

endpackage

### hdl/adt_lookup.sv
module adt_lookup (
  input  logic [adt_pkg::Slots-1:0] active_i,
  input  logic [31:0]               ident_i [adt_pkg::Slots],
  input  logic [31:0]               entity_id_i,
  output adt_pkg::lookup_t          lookup_o
);

  logic [adt_pkg::Slots-1:0] match;

  always_comb begin
    for (int i = 0; i < adt_pkg::Slots; i++) begin
      match[i] = active_i[i] && (ident_i[i] == entity_id_i);
    end
  end

  // Walk from the top down so the lowest qualifying slot wins.
  always_comb begin
    lookup_o = '0;
    for (int i = adt_pkg::Slots - 1; i >= 0; i--) begin
      if (match[i]) begin
        lookup_o.hit     = 1'b1;
        lookup_o.hit_idx = adt_pkg::SlotW'(i);
      end
      if (!active_i[i]) begin
        lookup_o.free_found = 1'b1;
        lookup_o.free_idx   = adt_pkg::SlotW'(i);
      end
    end
  end

endmodule

### hdl/aging_dedup_table.sv
// A new beat may be started in every cycle: busy_o stays low, so an item is taken at each
// clock edge where start_i is high. Its result passes the input register and the result
// register and appears on the result ports for a single cycle, marked by result_valid_o,
// and the receiver cannot stall it. Between the two registers lies one pass of parallel
// identifier compares, age compares and lowest-slot encoding over the entries held in
// flip-flops, whose table update lands at the same edge as the result, so the next item
// already sees it. The lifetime register is written whenever lifetime_ticks_we_i is high
// and should only change while no beat is in flight.
`include "aging_dedup_table_defines.svh"

module aging_dedup_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] current_time_i,
  input  logic [31:0] entity_id_i,
  input  logic        qualifies_i,
  input  logic        lifetime_ticks_we_i,
  input  logic [31:0] lifetime_ticks_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic        trigger_o,
  output logic [4:0]  slot_index_o
);

  logic [31:0] lifetime_q;

  logic        in_valid_q;
  logic        in_op_q;
  logic [31:0] in_time_q;
  logic [31:0] in_id_q;
  logic        in_qual_q;

  logic [adt_pkg::Slots-1:0] active_q, active_d;
  logic [31:0]               stamp_q [adt_pkg::Slots];
  logic [31:0]               ident_q [adt_pkg::Slots];

  logic [adt_pkg::Slots-1:0] expire;
  adt_pkg::lookup_t          lkup;

  logic                      stamp_we;
  logic                      ident_we;
  logic [adt_pkg::SlotW-1:0] wr_idx;

  logic                      res_valid_q;
  adt_pkg::status_e          res_status_q, res_status_d;
  logic [adt_pkg::SlotW-1:0] res_idx_q, res_idx_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= adt_pkg::LifetimeReset;
    end else if (lifetime_ticks_we_i) begin
      lifetime_q <= lifetime_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_op_q   <= opcode_i;
      in_time_q <= current_time_i;
      in_id_q   <= entity_id_i;
      in_qual_q <= qualifies_i;
    end
  end

  always_comb begin
    for (int i = 0; i < adt_pkg::Slots; i++) begin
      expire[i] = active_q[i] && (32'(in_time_q - stamp_q[i]) >= lifetime_q);
    end
  end

  adt_lookup u_lookup (
    .active_i    (active_q),
    .ident_i     (ident_q),
    .entity_id_i (in_id_q),
    .lookup_o    (lkup)
  );

  always_comb begin
    active_d     = active_q;
    stamp_we     = 1'b0;
    ident_we     = 1'b0;
    wr_idx       = lkup.hit_idx;
    res_status_d = adt_pkg::StSwept;
    res_idx_d    = '0;
    if (in_op_q == adt_pkg::OpAge) begin
      active_d = active_q & ~expire;
    end else if (lkup.hit) begin
      stamp_we     = 1'b1;
      res_status_d = adt_pkg::StHit;
      res_idx_d    = lkup.hit_idx;
    end else if (!in_qual_q) begin
      res_status_d = adt_pkg::StNotQual;
    end else if (lkup.free_found) begin
      stamp_we             = 1'b1;
      ident_we             = 1'b1;
      wr_idx               = lkup.free_idx;
      active_d[wr_idx]     = 1'b1;
      res_status_d         = adt_pkg::StInserted;
      res_idx_d            = lkup.free_idx;
    end else begin
      res_status_d = adt_pkg::StFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (in_valid_q) begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < adt_pkg::Slots; i++) begin
      if (in_valid_q && wr_idx == adt_pkg::SlotW'(i)) begin
        if (stamp_we) begin
          stamp_q[i] <= in_time_q;
        end
        if (ident_we) begin
          ident_q[i] <= in_id_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign trigger_o      = (res_status_q == adt_pkg::StInserted) ||
                          (res_status_q == adt_pkg::StFull);
  assign slot_index_o   = 5'(res_idx_q);

  `ADT_ASSERT(a_latency, start_i && !busy_o |-> ##2 result_valid_o, "result beat missing")
  `ADT_ASSERT(a_insert_active, res_valid_q && res_status_q == adt_pkg::StInserted |-> active_q[res_idx_q], "inserted slot not active")
  `ADT_ASSERT(a_hit_active, in_valid_q && in_op_q == adt_pkg::OpNotify && lkup.hit |-> active_q[lkup.hit_idx], "hit on inactive slot")
  `ADT_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !result_valid_o, "result beat during reset")

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 400;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned Phases = 12;
  localparam int unsigned PhaseItems = 125;
  localparam int unsigned PoolDepth = 64;

  typedef struct packed {
    adt_pkg::status_e status;
    logic             trigger;
    logic [4:0]       slot;
  } outcome_t;

  typedef struct packed {
    adt_pkg::op_e op;
    logic [31:0]  now;
    logic [31:0]  id;
    logic         qual;
    logic         typed;
    outcome_t     outcome;
  } row_t;

  localparam outcome_t Unchecked = '{adt_pkg::StSwept, 1'b0, 5'd0};

  localparam row_t DirectedRows [18] = '{
    '{adt_pkg::OpNotify, 32'd0, 32'h0000_0000, 1'b0, 1'b1, '{adt_pkg::StNotQual, 1'b0, 5'd0}},
    '{adt_pkg::OpAge, 32'd0, 32'h0000_0000, 1'b0, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}},
    '{adt_pkg::OpNotify, 32'd100, 32'hFFFF_FFFF, 1'b1, 1'b1, '{adt_pkg::StInserted, 1'b1, 5'd0}},
    '{adt_pkg::OpNotify, 32'd200, 32'hFFFF_FFFF, 1'b0, 1'b1, '{adt_pkg::StHit, 1'b0, 5'd0}},
    '{adt_pkg::OpNotify, 32'd300, 32'h0000_0000, 1'b1, 1'b1, '{adt_pkg::StInserted, 1'b1, 5'd1}},
    '{adt_pkg::OpNotify, 32'd400, 32'h0000_0000, 1'b1, 1'b1, '{adt_pkg::StHit, 1'b0, 5'd1}},
    '{adt_pkg::OpAge, 32'd5199, 32'hFFFF_FFFF, 1'b1, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}},
    '{adt_pkg::OpAge, 32'd5200, 32'h0000_0000, 1'b0, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}},
    '{adt_pkg::OpNotify, 32'd5210, 32'hFFFF_FFFF, 1'b0, 1'b0, Unchecked},
    '{adt_pkg::OpNotify, 32'd5220, 32'h0000_0000, 1'b0, 1'b0, Unchecked},
    '{adt_pkg::OpNotify, 32'd5230, 32'hA5A5_A5A5, 1'b1, 1'b0, Unchecked},
    '{adt_pkg::OpNotify, 32'hFFFF_FF00, 32'h5A5A_5A5A, 1'b1, 1'b0, Unchecked},
    '{adt_pkg::OpAge, 32'h0000_0010, 32'h1234_5678, 1'b0, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}},
    '{adt_pkg::OpNotify, 32'h0000_0020, 32'h5A5A_5A5A, 1'b0, 1'b0, Unchecked},
    '{adt_pkg::OpAge, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}},
    '{adt_pkg::OpNotify, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, Unchecked},
    '{adt_pkg::OpNotify, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, Unchecked},
    '{adt_pkg::OpAge, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{adt_pkg::StSwept, 1'b0, 5'd0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [31:0] current_time_i;
  logic [31:0] entity_id_i;
  logic        qualifies_i;
  logic        lifetime_ticks_we_i;
  logic [31:0] lifetime_ticks_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic        trigger_o;
  logic [4:0]  slot_index_o;

  logic        entry_on [adt_pkg::Slots];
  logic [31:0] entry_time [adt_pkg::Slots];
  logic [31:0] entry_id [adt_pkg::Slots];
  logic [31:0] lifetime_q;

  outcome_t    pending_outcomes [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  aging_dedup_table dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .opcode_i            (opcode_i),
    .current_time_i      (current_time_i),
    .entity_id_i         (entity_id_i),
    .qualifies_i         (qualifies_i),
    .lifetime_ticks_we_i (lifetime_ticks_we_i),
    .lifetime_ticks_i    (lifetime_ticks_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .trigger_o           (trigger_o),
    .slot_index_o        (slot_index_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic outcome_t lookup_outcome(adt_pkg::op_e op, logic [31:0] now,
                                              logic [31:0] id, logic qual);
    outcome_t    res;
    logic [31:0] age;
    int          i;
    res = '{adt_pkg::StSwept, 1'b0, 5'd0};
    if (op == adt_pkg::OpAge) begin
      for (i = 0; i < adt_pkg::Slots; i++) begin
        age = now - entry_time[i];
        if (entry_on[i] && age >= lifetime_q) entry_on[i] = 1'b0;
      end
      return res;
    end
    for (i = 0; i < adt_pkg::Slots; i++) begin
      if (entry_on[i] && entry_id[i] == id) begin
        entry_time[i] = now;
        res = '{adt_pkg::StHit, 1'b0, i[4:0]};
        return res;
      end
    end
    if (!qual) begin
      res = '{adt_pkg::StNotQual, 1'b0, 5'd0};
      return res;
    end
    for (i = 0; i < adt_pkg::Slots; i++) begin
      if (!entry_on[i]) begin
        entry_on[i] = 1'b1;
        entry_time[i] = now;
        entry_id[i] = id;
        res = '{adt_pkg::StInserted, 1'b1, i[4:0]};
        return res;
      end
    end
    res = '{adt_pkg::StFull, 1'b1, 5'd0};
    return res;
  endfunction

  task automatic issue_item(adt_pkg::op_e op, logic [31:0] now, logic [31:0] id, logic qual,
                            logic typed, outcome_t given);
    int       gap;
    outcome_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    current_time_i <= now;
    entity_id_i <= id;
    qualifies_i <= qual;
    do @(posedge clk_i); while (busy_o);
    predicted = lookup_outcome(op, now, id, qual);
    pending_outcomes.push_back(typed ? given : predicted);
  endtask

  task automatic quiesce();
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_lifetime(logic [31:0] value);
    quiesce();
    lifetime_ticks_we_i <= 1'b1;
    lifetime_ticks_i <= value;
    @(posedge clk_i);
    lifetime_ticks_we_i <= 1'b0;
    lifetime_q = value;
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing pending: status %0d", status_o);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (trigger_o !== want.trigger) begin
          $error("trigger expected %0d, got %0d", want.trigger, trigger_o);
          mismatches++;
        end
        if (slot_index_o !== want.slot) begin
          $error("slot_index expected %0d, got %0d", want.slot, slot_index_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    row_t         r;
    int           ph;
    int           k;
    int           pool_size;
    logic [31:0]  step_max;
    logic [31:0]  now_ticks;
    logic [31:0]  lt;
    logic [31:0]  id;
    logic [31:0]  id_pool [PoolDepth];
    adt_pkg::op_e op;

    rst_ni <= 1'b0;
    start_i <= 1'b0;
    opcode_i <= adt_pkg::OpAge;
    current_time_i <= '0;
    entity_id_i <= '0;
    qualifies_i <= 1'b0;
    lifetime_ticks_we_i <= 1'b0;
    lifetime_ticks_i <= '0;
    for (k = 0; k < adt_pkg::Slots; k++) begin
      entry_on[k] = 1'b0;
      entry_time[k] = '0;
      entry_id[k] = '0;
    end
    lifetime_q = adt_pkg::LifetimeReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[k]) begin
      r = DirectedRows[k];
      issue_item(r.op, r.now, r.id, r.qual, r.typed, r.outcome);
    end

    for (ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: lt = '0;
        1: lt = 32'd1;
        2: lt = '1;
        3: lt = adt_pkg::LifetimeReset;
        default: lt = ph[0] ? $urandom : $urandom_range(1, 20000);
      endcase
      write_lifetime(lt);
      case ($urandom_range(0, 4))
        0: pool_size = 3;
        1: pool_size = 16;
        2: pool_size = 33;
        3: pool_size = 48;
        default: pool_size = 64;
      endcase
      if (ph == 2) pool_size = PoolDepth;
      case ($urandom_range(0, 3))
        0: step_max = 32'd3;
        1: step_max = 32'd1000;
        2: step_max = 32'd20000;
        default: step_max = 32'h0FFF_FFFF;
      endcase
      foreach (id_pool[k]) id_pool[k] = $urandom;
      now_ticks = $urandom;
      for (k = 0; k < PhaseItems; k++) begin
        if (k % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        if (k == PhaseItems / 2 && ph[1]) quiesce();
        if ($urandom_range(0, 19) == 0) now_ticks = $urandom;
        else now_ticks = now_ticks + $urandom_range(0, step_max);
        op = ($urandom_range(0, 99) < 12) ? adt_pkg::OpAge : adt_pkg::OpNotify;
        id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, pool_size - 1)];
        issue_item(op, now_ticks, id, $urandom_range(0, 9) < 7, 1'b0, Unchecked);
      end
    end

    quiesce();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
